@@ hw/rtl/lzwp_pkg.sv @@
// ----------------------------------------------------------------------------
// lzwp_pkg
// Shared constants and types of the LZW compressor and symbol packer.
// ----------------------------------------------------------------------------
package lzwp_pkg;

	// Dictionary and hash table sizing
	localparam int DICT_ENTRIES = 4096;
	localparam int TABLE_SLOTS  = 8192;
	localparam int CODE_W       = $clog2(DICT_ENTRIES);
	localparam int NEXT_W       = CODE_W + 1;
	localparam int SLOT_W       = $clog2(TABLE_SLOTS);
	localparam int KEY_W        = CODE_W + 8;
	localparam int ENTRY_W      = 1 + KEY_W + CODE_W;
	localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

	// Code width control
	localparam int END_CODE   = 2;
	localparam int FIRST_CODE = 3;
	localparam int WIDTH_CAP  = 15;
	localparam int CW_W       = 4;
	localparam int ENL_W      = WIDTH_CAP;
	localparam int CW_RESET   = 2;
	localparam int ENL_RESET  = 2;

	// Bit packing
	localparam int VAL_W     = WIDTH_CAP + 8;
	localparam int NB_W      = $clog2(VAL_W + 1);
	localparam int MAX_OUT   = 64;
	localparam int CNT_W     = $clog2(MAX_OUT + 1);
	localparam int BPS_W     = 4;
	localparam int BPS_RESET = 6;
	localparam int SYM_W     = 8;

	// Queue sizing
	localparam int CMDQ_DEPTH = 4;
	localparam int OUTQ_DEPTH = 4;

	// One emission command from the front to the back
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [NB_W-1:0]  nbits;
		logic             flush;
		logic             ovf;
		logic             first;
	} cmd_t;

	// Queue status seen by producer and consumer
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// One finished symbol
	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             stream_end;
		logic             overflow;
	} sym_t;

endpackage

@@ hw/rtl/lzw_compressor_symbol_packer_core.sv @@
// Full stays high while the front handles a byte: a byte that opens a stream, a
// dictionary hit (with one more probe per hash collision), or a code emission and pair add;
// the final byte also emits its prefix, the end code and the flush.
// The bit packer loads each command, then shifts one code bit per cycle unless a finished
// symbol meets a full symbol queue; the front waits with full high while the command queue is full.
// Reset and each stream end start a table clearing pass with full high.
// ----------------------------------------------------------------------------
// lzw_compressor_symbol_packer_core
// LZW compressor with growing code width and packing into small symbols.
// ----------------------------------------------------------------------------
module lzw_compressor_symbol_packer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  data_byte,
	input  logic                        final_byte,
	output logic                        empty,
	input  logic                        pop,
	output logic [lzwp_pkg::SYM_W-1:0]  symbol,
	output logic                        stream_end,
	output logic                        overflow,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lzwp_pkg::BPS_W-1:0]  cfg_data
);

	logic [lzwp_pkg::BPS_W-1:0] bps_q;
	logic                       cmd_push;
	logic                       cmd_pop;
	lzwp_pkg::cmd_t             cmd_wr;
	lzwp_pkg::cmd_t             cmd_rd;
	lzwp_pkg::q_stat_t          cmdq_stat;

	assign cfg_ready = 1'b1;

	// Symbol width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q <= lzwp_pkg::BPS_W'(lzwp_pkg::BPS_RESET);
		end else if (cfg_valid && cfg_ready) begin
			bps_q <= cfg_data;
		end
	end

	lzwp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.full       (full),
		.cmd_push   (cmd_push),
		.cmd_data   (cmd_wr),
		.cmdq_stat  (cmdq_stat)
	);

	lzwp_cmd_q u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_wr),
		.pop    (cmd_pop),
		.rdata  (cmd_rd),
		.stat   (cmdq_stat)
	);

	lzwp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.bits_per_symbol (bps_q),
		.cmd_rd          (cmd_rd),
		.cmdq_stat       (cmdq_stat),
		.cmd_pop         (cmd_pop),
		.empty           (empty),
		.pop             (pop),
		.symbol          (symbol),
		.stream_end      (stream_end),
		.overflow        (overflow)
	);

endmodule

@@ hw/rtl/lzwp_ram.sv @@
// ----------------------------------------------------------------------------
// lzwp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lzwp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/lzwp_cmd_q.sv @@
// ----------------------------------------------------------------------------
// lzwp_cmd_q
// Short command queue between the dictionary front and the bit packer.
// ----------------------------------------------------------------------------
module lzwp_cmd_q (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  lzwp_pkg::cmd_t         wdata,
	input  logic                   pop,
	output lzwp_pkg::cmd_t         rdata,
	output lzwp_pkg::q_stat_t      stat
);

	localparam int AW = $clog2(lzwp_pkg::CMDQ_DEPTH);

	lzwp_pkg::cmd_t entry_q [lzwp_pkg::CMDQ_DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;
	logic           do_push;
	logic           do_pop;

	assign stat.full  = (count_q == (AW+1)'(lzwp_pkg::CMDQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = entry_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/lzwp_front.sv @@
// ----------------------------------------------------------------------------
// lzwp_front
// Accepts bytes, keeps the LZW dictionary and code width, and issues
// emission commands for the bit packer.
// ----------------------------------------------------------------------------
module lzwp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [7:0]           data_byte,
	input  logic                 final_byte,
	output logic                 full,
	output logic                 cmd_push,
	output lzwp_pkg::cmd_t       cmd_data,
	input  lzwp_pkg::q_stat_t    cmdq_stat
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAP,
		S_HASH,
		S_CHECK,
		S_EMIT,
		S_ENL2,
		S_INSERT,
		S_END,
		S_FLUSH,
		S_CLEAR
	} state_t;

	state_t                          state_q;
	logic [7:0]                      byte_q;
	logic                            last_q;
	logic                            first_q;
	logic                            final_ph_q;
	logic [lzwp_pkg::CODE_W-1:0]     cur_code_q;
	logic [lzwp_pkg::KEY_W-1:0]      key_q;
	logic [lzwp_pkg::SLOT_W-1:0]     slot_q;
	logic [lzwp_pkg::SLOT_W-1:0]     clr_cnt_q;
	logic [lzwp_pkg::CODE_W-1:0]     prefix_code_q;
	logic                            prefix_valid_q;
	logic                            prefix_single_q;
	logic [7:0]                      prefix_byte_q;
	logic [lzwp_pkg::NEXT_W-1:0]     next_code_q;
	logic [lzwp_pkg::ENL_W-1:0]      enl_q;
	logic [lzwp_pkg::CW_W-1:0]       cw_q;
	logic                            ovf_q;
	logic [255:0]                    byte_valid_q;
	logic [255:0]                    lit_pend_q;

	logic                            dict_full;
	logic [lzwp_pkg::CODE_W-1:0]     map_code;
	logic [lzwp_pkg::CODE_W-1:0]     cur_code;
	logic [lzwp_pkg::CODE_W-1:0]     bmap_rd;
	logic                            map_we;
	logic [lzwp_pkg::ENTRY_W-1:0]    pair_rd;
	logic [lzwp_pkg::ENTRY_W-1:0]    pair_wdata;
	logic [lzwp_pkg::SLOT_W-1:0]     pair_waddr;
	logic [lzwp_pkg::SLOT_W-1:0]     pair_raddr;
	logic                            pair_we;
	logic [lzwp_pkg::SLOT_W-1:0]     hash_slot;
	logic                            ent_valid;
	logic [lzwp_pkg::KEY_W-1:0]      ent_key;
	logic [lzwp_pkg::CODE_W-1:0]     ent_code;
	logic                            lit;
	logic [lzwp_pkg::CW_W+lzwp_pkg::ENL_W-1:0] enl_next;
	state_t                          route;

	// One step of the code width counter
	function automatic logic [lzwp_pkg::CW_W+lzwp_pkg::ENL_W-1:0] enlarge_f(
		input logic [lzwp_pkg::CW_W-1:0]  cw,
		input logic [lzwp_pkg::ENL_W-1:0] enl
	);
		logic [lzwp_pkg::CW_W-1:0]  c;
		logic [lzwp_pkg::ENL_W-1:0] e;
		c = cw;
		e = enl;
		if (cw < lzwp_pkg::CW_W'(lzwp_pkg::WIDTH_CAP)) begin
			if (e != '0) begin
				e = e - 1'b1;
			end
			if (e == '0) begin
				e = lzwp_pkg::ENL_W'(1) << cw;
				c = cw + 1'b1;
			end
		end
		return {c, e};
	endfunction

	assign full      = (state_q != S_IDLE);
	assign dict_full = (next_code_q >= lzwp_pkg::NEXT_W'(lzwp_pkg::DICT_ENTRIES));
	assign map_code  = dict_full ? '0 : next_code_q[lzwp_pkg::CODE_W-1:0];
	assign cur_code  = byte_valid_q[byte_q] ? bmap_rd : map_code;
	assign map_we    = (state_q == S_MAP) && !byte_valid_q[byte_q];
	assign lit       = prefix_single_q && lit_pend_q[prefix_byte_q];
	assign enl_next  = enlarge_f(cw_q, enl_q);
	assign route     = final_ph_q ? S_END : S_INSERT;

	// Hash of the pair key: low bits of the multiplicative hash
	assign hash_slot = lzwp_pkg::SLOT_W'(key_q * lzwp_pkg::HASH_MULT[lzwp_pkg::SLOT_W-1:0]);

	// Split the table entry
	assign ent_valid = pair_rd[lzwp_pkg::ENTRY_W-1];
	assign ent_key   = pair_rd[lzwp_pkg::ENTRY_W-2 -: lzwp_pkg::KEY_W];
	assign ent_code  = pair_rd[lzwp_pkg::CODE_W-1:0];

	// Probe address: first slot from the hash, then linear steps
	always_comb begin
		case (state_q)
			S_HASH:  pair_raddr = hash_slot;
			S_CHECK: pair_raddr = slot_q + 1'b1;
			default: pair_raddr = slot_q;
		endcase
	end

	// Table writes: clearing sweep or new pair
	assign pair_we    = (state_q == S_CLEAR) ||
		((state_q == S_INSERT) && !dict_full);
	assign pair_waddr = (state_q == S_CLEAR) ? clr_cnt_q : slot_q;
	assign pair_wdata = (state_q == S_CLEAR) ? '0 :
		{1'b1, key_q, next_code_q[lzwp_pkg::CODE_W-1:0]};

	// Build emission commands
	always_comb begin
		cmd_data       = '0;
		cmd_data.ovf   = ovf_q;
		cmd_data.first = first_q;
		cmd_push       = 1'b0;
		case (state_q)
			S_EMIT: begin
				cmd_push = !cmdq_stat.full;
				if (lit) begin
					cmd_data.value = lzwp_pkg::VAL_W'(prefix_byte_q) << cw_q;
					cmd_data.nbits = lzwp_pkg::NB_W'(cw_q) + lzwp_pkg::NB_W'(8);
				end else begin
					cmd_data.value = lzwp_pkg::VAL_W'(prefix_code_q);
					cmd_data.nbits = lzwp_pkg::NB_W'(cw_q);
				end
			end
			S_END: begin
				cmd_push       = !cmdq_stat.full;
				cmd_data.value = lzwp_pkg::VAL_W'(lzwp_pkg::END_CODE);
				cmd_data.nbits = lzwp_pkg::NB_W'(cw_q);
			end
			S_FLUSH: begin
				cmd_push       = !cmdq_stat.full;
				cmd_data.flush = 1'b1;
			end
			default: cmd_push = 1'b0;
		endcase
	end

	// Byte to code map
	lzwp_ram #(
		.WIDTH(lzwp_pkg::CODE_W),
		.DEPTH(256)
	) u_bmap (
		.clk   (clk),
		.we    (map_we),
		.waddr (byte_q),
		.wdata (map_code),
		.raddr (data_byte),
		.rdata (bmap_rd)
	);

	// Pair hash table
	lzwp_ram #(
		.WIDTH(lzwp_pkg::ENTRY_W),
		.DEPTH(lzwp_pkg::TABLE_SLOTS)
	) u_pair (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pair_waddr),
		.wdata (pair_wdata),
		.raddr (pair_raddr),
		.rdata (pair_rd)
	);

	// Sequencer for one byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			byte_q          <= '0;
			last_q          <= 1'b0;
			first_q         <= 1'b0;
			final_ph_q      <= 1'b0;
			cur_code_q      <= '0;
			key_q           <= '0;
			slot_q          <= '0;
			clr_cnt_q       <= '0;
			prefix_code_q   <= '0;
			prefix_valid_q  <= 1'b0;
			prefix_single_q <= 1'b0;
			prefix_byte_q   <= '0;
			next_code_q     <= lzwp_pkg::NEXT_W'(lzwp_pkg::FIRST_CODE);
			enl_q           <= lzwp_pkg::ENL_W'(lzwp_pkg::ENL_RESET);
			cw_q            <= lzwp_pkg::CW_W'(lzwp_pkg::CW_RESET);
			ovf_q           <= 1'b0;
			byte_valid_q    <= '0;
			lit_pend_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (push) begin
						byte_q  <= data_byte;
						last_q  <= final_byte;
						first_q <= 1'b1;
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					// Register a byte seen for the first time
					if (!byte_valid_q[byte_q]) begin
						byte_valid_q[byte_q] <= 1'b1;
						lit_pend_q[byte_q]   <= 1'b1;
						if (dict_full) begin
							ovf_q <= 1'b1;
						end else begin
							next_code_q <= next_code_q + 1'b1;
						end
					end
					cur_code_q <= cur_code;
					if (!prefix_valid_q) begin
						prefix_valid_q  <= 1'b1;
						prefix_single_q <= 1'b1;
						prefix_byte_q   <= byte_q;
						prefix_code_q   <= cur_code;
						final_ph_q      <= 1'b1;
						state_q         <= last_q ? S_EMIT : S_IDLE;
					end else begin
						key_q   <= {prefix_code_q, byte_q};
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					slot_q  <= hash_slot;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!ent_valid) begin
						final_ph_q <= 1'b0;
						state_q    <= S_EMIT;
					end else if (ent_key == key_q) begin
						prefix_code_q   <= ent_code;
						prefix_single_q <= 1'b0;
						final_ph_q      <= 1'b1;
						state_q         <= last_q ? S_EMIT : S_IDLE;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (!cmdq_stat.full) begin
						{cw_q, enl_q} <= enl_next;
						first_q       <= 1'b0;
						if (lit) begin
							lit_pend_q[prefix_byte_q] <= 1'b0;
							state_q <= S_ENL2;
						end else begin
							state_q <= route;
						end
					end
				end
				S_ENL2: begin
					{cw_q, enl_q} <= enl_next;
					state_q       <= route;
				end
				S_INSERT: begin
					if (dict_full) begin
						ovf_q <= 1'b1;
					end else begin
						next_code_q <= next_code_q + 1'b1;
					end
					prefix_single_q <= 1'b1;
					prefix_byte_q   <= byte_q;
					prefix_code_q   <= cur_code_q;
					final_ph_q      <= 1'b1;
					state_q         <= last_q ? S_EMIT : S_IDLE;
				end
				S_END: begin
					if (!cmdq_stat.full) begin
						first_q <= 1'b0;
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					// Close the stream and drop all dictionary state
					if (!cmdq_stat.full) begin
						first_q         <= 1'b0;
						prefix_code_q   <= '0;
						prefix_valid_q  <= 1'b0;
						prefix_single_q <= 1'b0;
						prefix_byte_q   <= '0;
						next_code_q     <= lzwp_pkg::NEXT_W'(lzwp_pkg::FIRST_CODE);
						enl_q           <= lzwp_pkg::ENL_W'(lzwp_pkg::ENL_RESET);
						cw_q            <= lzwp_pkg::CW_W'(lzwp_pkg::CW_RESET);
						ovf_q           <= 1'b0;
						byte_valid_q    <= '0;
						lit_pend_q      <= '0;
						clr_cnt_q       <= '0;
						state_q         <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/lzwp_back.sv @@
// ----------------------------------------------------------------------------
// lzwp_back
// Shifts command bits LSB first into symbols and queues finished symbols.
// ----------------------------------------------------------------------------
module lzwp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lzwp_pkg::BPS_W-1:0]  bits_per_symbol,
	input  lzwp_pkg::cmd_t              cmd_rd,
	input  lzwp_pkg::q_stat_t           cmdq_stat,
	output logic                        cmd_pop,
	output logic                        empty,
	input  logic                        pop,
	output logic [lzwp_pkg::SYM_W-1:0]  symbol,
	output logic                        stream_end,
	output logic                        overflow
);

	localparam int OAW = $clog2(lzwp_pkg::OUTQ_DEPTH);

	logic                          act_q;
	lzwp_pkg::cmd_t                cur_q;
	logic [lzwp_pkg::NB_W-1:0]     left_q;
	logic [7:0]                    accum_q;
	logic [2:0]                    pos_q;
	logic [lzwp_pkg::CNT_W-1:0]    cnt_q;
	lzwp_pkg::sym_t                oq_q [lzwp_pkg::OUTQ_DEPTH];
	logic [OAW-1:0]                owr_q;
	logic [OAW-1:0]                ord_q;
	logic [OAW:0]                  ocnt_q;

	logic [lzwp_pkg::BPS_W-1:0]    sym_w;
	logic                          bit_in;
	logic [7:0]                    nacc;
	logic                          sym_done;
	logic                          room;
	logic                          skip;
	logic                          need;
	logic                          stall;
	logic                          advance;
	logic                          cmd_done;
	logic                          oq_full;
	logic                          o_push;
	logic                          o_pop;
	lzwp_pkg::sym_t                o_new;

	// Clamp the symbol width to 1..8
	always_comb begin
		if (bits_per_symbol == '0) begin
			sym_w = lzwp_pkg::BPS_W'(1);
		end else if (bits_per_symbol > lzwp_pkg::BPS_W'(8)) begin
			sym_w = lzwp_pkg::BPS_W'(8);
		end else begin
			sym_w = bits_per_symbol;
		end
	end

	assign bit_in   = cur_q.flush ? 1'b0 : cur_q.value[0];
	assign nacc     = {accum_q[6:0], bit_in};
	assign sym_done = (lzwp_pkg::BPS_W'(pos_q) + 1'b1) >= sym_w;
	assign room     = (cnt_q < lzwp_pkg::CNT_W'(lzwp_pkg::MAX_OUT));
	assign skip     = act_q && cur_q.flush && !room;
	assign need     = act_q && !skip && sym_done && room;
	assign oq_full  = (ocnt_q == (OAW+1)'(lzwp_pkg::OUTQ_DEPTH));
	assign stall    = need && oq_full;
	assign advance  = act_q && !skip && !stall;
	assign cmd_done = cur_q.flush ? sym_done : (left_q == lzwp_pkg::NB_W'(1));
	assign cmd_pop  = !act_q && !cmdq_stat.empty;
	assign o_push   = need && !oq_full;
	assign o_pop    = pop && !empty;

	assign o_new.symbol     = nacc;
	assign o_new.stream_end = cur_q.flush;
	assign o_new.overflow   = cur_q.ovf;

	assign empty      = (ocnt_q == '0);
	assign symbol     = oq_q[ord_q].symbol;
	assign stream_end = oq_q[ord_q].stream_end;
	assign overflow   = oq_q[ord_q].overflow;

	// Hold finished symbols
	always_ff @(posedge clk) begin
		if (o_push) begin
			oq_q[owr_q] <= o_new;
		end
	end

	// Load commands, shift one bit per cycle unless the symbol queue stalls, count symbols per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			cur_q   <= '0;
			left_q  <= '0;
			accum_q <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			owr_q   <= '0;
			ord_q   <= '0;
			ocnt_q  <= '0;
		end else begin
			if (cmd_pop) begin
				act_q  <= 1'b1;
				cur_q  <= cmd_rd;
				left_q <= cmd_rd.nbits;
				if (cmd_rd.first) begin
					cnt_q <= '0;
				end
			end else if (skip) begin
				act_q   <= 1'b0;
				accum_q <= '0;
				pos_q   <= '0;
			end else if (advance) begin
				accum_q     <= sym_done ? 8'd0 : nacc;
				pos_q       <= sym_done ? 3'd0 : pos_q + 1'b1;
				cur_q.value <= cur_q.value >> 1;
				left_q      <= left_q - 1'b1;
				if (need) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (cmd_done) begin
					act_q <= 1'b0;
				end
			end
			if (o_push) begin
				owr_q <= owr_q + 1'b1;
			end
			if (o_pop) begin
				ord_q <= ord_q + 1'b1;
			end
			case ({o_push, o_pop})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/lzwp_checker.sv @@
// ----------------------------------------------------------------------------
// lzwp_checker
// Port-level checks of the LZW compressor, bound to the top level.
// ----------------------------------------------------------------------------
module lzwp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        push,
	input logic                        full,
	input logic                        empty,
	input logic                        pop,
	input logic [lzwp_pkg::SYM_W-1:0]  symbol,
	input logic                        stream_end,
	input logic                        overflow,
	input logic                        cfg_valid,
	input logic                        cfg_ready
);

	// Front is busy right after taking a byte
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("input accepted twice in a row");

	// Table clearing pass holds input off after reset
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> full)
		else $error("input open during clearing pass");

	// Waiting result holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(symbol) && $stable(stream_end)
			&& $stable(overflow))
		else $error("waiting result changed");

	// Configuration writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind lzw_compressor_symbol_packer_core lzwp_checker u_lzwp_checker (.*);
